/* hdl/pcf_pkg.sv */
// Package: word types and fixed widths for the pair cutoff filter.
package pcf_pkg;

  localparam int IDX_W = 6;
  localparam int POS_W = 32;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF_ENABLE   = 3'd0,
    REG_PERIODIC_ENABLE = 3'd1,
    REG_CUTOFF_LENGTH   = 3'd2,
    REG_BOX_X           = 3'd3,
    REG_BOX_Y           = 3'd4,
    REG_BOX_Z           = 3'd5
  } cfg_reg_t;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        index_i;
    logic [IDX_W-1:0]        index_j;
    logic                    skip_value;
    logic signed [POS_W-1:0] pos_i_x;
    logic signed [POS_W-1:0] pos_i_y;
    logic signed [POS_W-1:0] pos_i_z;
    logic signed [POS_W-1:0] pos_j_x;
    logic signed [POS_W-1:0] pos_j_y;
    logic signed [POS_W-1:0] pos_j_z;
  } in_word_t;

  typedef struct packed {
    logic skip_pair;
    logic skipped_by_list;
  } out_word_t;

endpackage

/* hdl/pcf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/pair_cutoff_filter_min_image_core.sv */
// Top level: pair cutoff filter with skip map and minimum image distance test.
//
// Input channel in_valid/in_stall/in_word carries write words (set or clear
// one skip map bit, no result) and query words (one result each).
// Output channel out_valid/out_stall/out_word returns skip_pair and
// skipped_by_list in query order.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle;
// the block does not enforce this. Throughput: one word per cycle while
// in_stall is low. Pipeline: an input register, the 32-stage remainder
// pipeline per axis, then wrap, square, two saturating adds and the compare.
// The skip map lives in a one-bit RAM of MAX_FRAGS*MAX_FRAGS entries; the
// query reads it in the accept cycle, a write stores in the accept cycle.
// Reset: configuration and valid registers clear, then a clearing pass writes
// zero to every skip map entry, with in_stall high.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises until the result is taken.
module pair_cutoff_filter_min_image_core #(
  parameter int MAX_FRAGS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pcf_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pcf_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [pcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcf_pkg::CFG_W-1:0]     cfg_data
);
  import pcf_pkg::*;

  localparam int DEPTH = MAX_FRAGS * MAX_FRAGS;
  localparam int AW = $clog2(DEPTH);
  localparam int NDIV = POS_W;

  logic        cutoff_enable, periodic_enable;
  logic [31:0] cutoff_length;
  logic [31:0] box [0:2];
  logic [63:0] cut2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_enable <= 1'b0;
      periodic_enable <= 1'b0;
      cutoff_length <= '0;
      box[0] <= '0;
      box[1] <= '0;
      box[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CUTOFF_ENABLE:   cutoff_enable <= cfg_data[0];
        REG_PERIODIC_ENABLE: periodic_enable <= cfg_data[0];
        REG_CUTOFF_LENGTH:   cutoff_length <= cfg_data;
        REG_BOX_X:           box[0] <= cfg_data;
        REG_BOX_Y:           box[1] <= cfg_data;
        REG_BOX_Z:           box[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cut2 <= cutoff_length * cutoff_length;
  end

  // clearing pass
  logic [AW:0] clr_cnt;
  logic        clr_done;
  assign clr_done = (clr_cnt == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  logic en, acc, in_range, ram_q, ram_we, ram_wd;
  logic [AW-1:0] addr, ram_wa;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en || !clr_done;
  assign acc = in_valid && !in_stall;
  assign in_range = (32'(in_word.index_i) < MAX_FRAGS) && (32'(in_word.index_j) < MAX_FRAGS);
  assign addr = AW'(32'(in_word.index_i) * MAX_FRAGS + 32'(in_word.index_j));
  assign ram_we = !clr_done || (acc && in_word.req_type == REQ_WRITE && in_range);
  assign ram_wa = clr_done ? addr : clr_cnt[AW-1:0];
  assign ram_wd = clr_done && in_word.skip_value;

  pcf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (en),
    .raddr (addr),
    .rdata (ram_q)
  );

  // stage 0 and remainder pipeline
  logic        dv [0:NDIV];
  logic        dl [0:NDIV];
  logic        inr0;
  logic [31:0] rm [0:NDIV][0:2];
  logic [31:0] dd [0:NDIV][0:2];
  logic [31:0] mo [0:NDIV][0:2];
  logic signed [POS_W:0] dlt [0:2];
  logic [31:0] mag [0:2];

  always_comb begin
    dlt[0] = {in_word.pos_j_x[POS_W-1], in_word.pos_j_x}
           - {in_word.pos_i_x[POS_W-1], in_word.pos_i_x};
    dlt[1] = {in_word.pos_j_y[POS_W-1], in_word.pos_j_y}
           - {in_word.pos_i_y[POS_W-1], in_word.pos_i_y};
    dlt[2] = {in_word.pos_j_z[POS_W-1], in_word.pos_j_z}
           - {in_word.pos_i_z[POS_W-1], in_word.pos_i_z};
    for (int a = 0; a < 3; a++) begin
      mag[a] = dlt[a][POS_W] ? 32'(-dlt[a]) : dlt[a][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NDIV; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= acc && in_word.req_type == REQ_QUERY;
      for (int k = 1; k <= NDIV; k++) dv[k] <= dv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] t;
    if (en) begin
      inr0 <= in_range;
      dl[0] <= 1'b0;
      dl[1] <= ram_q && inr0;
      for (int k = 2; k <= NDIV; k++) dl[k] <= dl[k-1];
      for (int a = 0; a < 3; a++) begin
        rm[0][a] <= '0;
        dd[0][a] <= mag[a];
        mo[0][a] <= mag[a];
        for (int k = 1; k <= NDIV; k++) begin
          t = {rm[k-1][a], dd[k-1][a][31]};
          if (t >= {1'b0, box[a]}) t = t - {1'b0, box[a]};
          rm[k][a] <= t[31:0];
          dd[k][a] <= {dd[k-1][a][30:0], 1'b0};
          mo[k][a] <= mo[k-1][a];
        end
      end
    end
  end

  // wrap, square, sum, compare
  logic        wv, qv, s1v, s2v;
  logic        wl, ql, s1l, s2l;
  logic [31:0] w [0:2];
  logic [63:0] sq [0:2];
  logic [63:0] s1, s1z, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
      qv <= 1'b0;
      s1v <= 1'b0;
      s2v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      wv <= dv[NDIV];
      qv <= wv;
      s1v <= qv;
      s2v <= s1v;
      out_valid <= s2v;
    end
  end

  always_ff @(posedge clk) begin
    logic [64:0] sum;
    if (en) begin
      wl <= dl[NDIV];
      for (int a = 0; a < 3; a++) begin
        if (!periodic_enable || box[a] == '0) begin
          w[a] <= mo[NDIV][a];
        end else if ({rm[NDIV][a], 1'b0} >= {1'b0, box[a]}) begin
          w[a] <= box[a] - rm[NDIV][a];
        end else begin
          w[a] <= rm[NDIV][a];
        end
      end
      ql <= wl;
      for (int a = 0; a < 3; a++) sq[a] <= w[a] * w[a];
      s1l <= ql;
      sum = {1'b0, sq[0]} + {1'b0, sq[1]};
      s1 <= sum[64] ? '1 : sum[63:0];
      s1z <= sq[2];
      s2l <= s1l;
      sum = {1'b0, s1} + {1'b0, s1z};
      s2 <= sum[64] ? '1 : sum[63:0];
      out_word.skipped_by_list <= s2l;
      out_word.skip_pair <= s2l || (cutoff_enable && s2 > cut2);
    end
  end

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> in_stall)
    else $error("input taken during skip map clear");
  a_list_implies_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.skipped_by_list |-> out_word.skip_pair)
    else $error("listed pair not skipped");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");
  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    s2v && en |=> out_valid)
    else $error("result lost at output register");
`endif

endmodule

/* dv/tb_pair_cutoff_filter_min_image_core.sv */
// Testbench: pair cutoff filter, random and directed words checked against a predictor.
`timescale 1ns / 100ps

module tb_pair_cutoff_filter_min_image_core;
  import pcf_pkg::*;

  localparam int NFRAG = 64;
  localparam int DRAIN = 60;
  localparam longint CYCLE_LIMIT = 2000000;

  class skip_scoreboard;
    bit skip_map [NFRAG*NFRAG];
    bit cut_en;
    bit per_en;
    logic [31:0] cut_len;
    logic [31:0] box [3];
    out_word_t pending[$];
    int errors;

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_CUTOFF_ENABLE: cut_en = val[0];
        REG_PERIODIC_ENABLE: per_en = val[0];
        REG_CUTOFF_LENGTH: cut_len = val;
        REG_BOX_X: box[0] = val;
        REG_BOX_Y: box[1] = val;
        REG_BOX_Z: box[2] = val;
        default: ;
      endcase
    endfunction

    function longint min_image(longint d, logic [31:0] b);
      longint unsigned m, q, bb;
      longint r;
      if (b == 0) return d;
      bb = b;
      m = (d < 0) ? -d : d;
      q = (2 * m + bb) / (2 * bb);
      r = longint'(m) - longint'(q * bb);
      return (d < 0) ? -r : r;
    endfunction

    function longint unsigned sq_sat(longint d);
      longint unsigned m;
      m = (d < 0) ? -d : d;
      if (m >= 64'h1_0000_0000) return '1;
      return m * m;
    endfunction

    function longint unsigned add_sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s < a) ? '1 : s;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      longint d [3];
      longint unsigned dist2, cut2;
      int key;
      key = w.index_i * NFRAG + w.index_j;
      if (w.req_type == REQ_WRITE) begin
        skip_map[key] = w.skip_value;
        return;
      end
      r = '0;
      if (skip_map[key]) begin
        r.skip_pair = 1'b1;
        r.skipped_by_list = 1'b1;
      end else if (cut_en) begin
        d[0] = longint'(w.pos_j_x) - longint'(w.pos_i_x);
        d[1] = longint'(w.pos_j_y) - longint'(w.pos_i_y);
        d[2] = longint'(w.pos_j_z) - longint'(w.pos_i_z);
        if (per_en)
          for (int a = 0; a < 3; a++) d[a] = min_image(d[a], box[a]);
        dist2 = add_sat(add_sat(sq_sat(d[0]), sq_sat(d[1])), sq_sat(d[2]));
        cut2 = longint'(cut_len) * longint'(cut_len);
        r.skip_pair = dist2 > cut2;
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %b", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.skip_pair !== exp_w.skip_pair) begin
        $error("skip_pair exp %b got %b", exp_w.skip_pair, got.skip_pair);
        errors++;
      end
      if (got.skipped_by_list !== exp_w.skipped_by_list) begin
        $error("skipped_by_list exp %b got %b", exp_w.skipped_by_list, got.skipped_by_list);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_word;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  longint cycles = 0;
  bit out_noise = 1;

  skip_scoreboard sb = new();

  pair_cutoff_filter_min_image_core u_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
  end

  always @(negedge clk) begin
    if (out_noise && $urandom_range(0, 99) < 25) out_stall <= ($urandom_range(0, 9) < 8);
    else if (!out_noise) out_stall <= 0;
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function logic [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  function in_word_t rand_word(int wr_pct);
    in_word_t w;
    int mode;
    mode = $urandom_range(0, 3);
    w.req_type = ($urandom_range(0, 99) < wr_pct) ? REQ_WRITE : REQ_QUERY;
    w.index_i = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 63));
    w.index_j = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 63));
    w.skip_value = 1'($urandom_range(0, 1));
    w.pos_i_x = rand_pos(mode);
    w.pos_i_y = rand_pos(mode);
    w.pos_i_z = rand_pos(mode);
    w.pos_j_x = rand_pos(mode);
    w.pos_j_y = rand_pos(mode);
    w.pos_j_z = rand_pos(mode);
    return w;
  endfunction

  function in_word_t make_query(logic [5:0] i, logic [5:0] j, logic [31:0] ix, logic [31:0] jx);
    in_word_t w;
    w = '0;
    w.req_type = REQ_QUERY;
    w.index_i = i;
    w.index_j = j;
    w.pos_i_x = ix;
    w.pos_j_x = jx;
    return w;
  endfunction

  task automatic run_phase(logic ce, logic pe, logic [31:0] cl, logic [31:0] bx,
                           logic [31:0] by, logic [31:0] bz, int n);
    wait_idle();
    write_reg(REG_CUTOFF_ENABLE, ce);
    write_reg(REG_PERIODIC_ENABLE, pe);
    write_reg(REG_CUTOFF_LENGTH, cl);
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    for (int k = 0; k < n; k++) send_word(rand_word(20));
  endtask

  initial begin
    in_word_t w;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: cutoff off, listed pair, extremes, half quotient, zero box
    send_word(make_query(0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    w = make_query(63, 63, 0, 0); w.req_type = REQ_WRITE; w.skip_value = 1'b1;
    send_word(w);
    send_word(make_query(63, 63, 0, 0));
    send_word(make_query(63, 62, 0, 0));
    w.skip_value = 1'b0;
    send_word(w);
    send_word(make_query(63, 63, 0, 0));
    wait_idle();
    write_reg(REG_CUTOFF_ENABLE, 1);
    write_reg(REG_PERIODIC_ENABLE, 1);
    write_reg(REG_CUTOFF_LENGTH, 32'h0001_0000);
    write_reg(REG_BOX_X, 32'h0004_0000);
    write_reg(REG_BOX_Y, 0);
    write_reg(REG_BOX_Z, 32'hFFFF_FFFF);
    send_word(make_query(1, 2, 0, 32'h0002_0000));
    send_word(make_query(1, 2, 0, 32'hFFFE_0000));
    send_word(make_query(1, 2, 0, 32'h0001_0000));
    send_word(make_query(1, 2, 0, 32'h0001_0001));
    send_word(make_query(1, 2, 0, 32'h0003_0001));
    send_word(make_query(1, 2, 32'h8000_0000, 32'h7FFF_FFFF));
    w = make_query(5, 6, 0, 0); w.pos_j_y = 32'h0001_0001;
    send_word(w);
    w.pos_j_y = 0; w.pos_i_z = 32'h8000_0000; w.pos_j_z = 32'h7FFF_FFFF;
    send_word(w);
    wait_idle();
    write_reg(REG_PERIODIC_ENABLE, 0);
    write_reg(REG_CUTOFF_LENGTH, 32'hFFFF_FFFF);
    send_word(make_query(1, 2, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_query(1, 2, 0, 32'h7FFF_FFFF));
    wait_idle();
    write_reg(REG_CUTOFF_LENGTH, 0);
    send_word(make_query(1, 2, 5, 5));
    send_word(make_query(1, 2, 5, 6));

    run_phase(1, 1, 32'h0002_0000, 32'h0005_0000, 32'h0003_8000, 32'h0010_0000, 200);
    out_noise = 0;
    run_phase(1, 0, 32'h0008_0000, 0, 0, 0, 150);
    out_noise = 1;
    run_phase(1, 1, $urandom(), $urandom(), $urandom_range(1, 7), 0, 150);
    run_phase(0, 1, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 100);
    run_phase(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 100);
    run_phase(1, 1, 32'h0004_0000, 32'h0002_0000, 32'h0006_0000, 32'h0003_0000, 100);

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
